// ===== design/cs_store_pkg.sv =====
`timescale 1ns / 1ps

package cs_store_pkg;

  // Operation codes carried in the op field of a transaction.
  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_ATTACH  = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_ADVANCE = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  // Status codes reported with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOCUR = 2'd2;

  // One command transaction.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] entry_value;
  } cs_in_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] current_value;
    logic        has_current;
    logic [6:0]  item_count;
    logic [6:0]  cursor_pos;
    logic [1:0]  status;
  } cs_out_t;

endpackage

// ===== design/cs_store_mem.sv =====
`timescale 1ns / 1ps

module cs_store_mem #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cs_store_seq.sv =====
`timescale 1ns / 1ps

module cs_store_seq #(
  parameter int CAPACITY = 64,
  parameter int DATA_W   = 32,
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  cs_store_pkg::cs_in_t  item_i,
  output logic                  busy_o,
  output logic                  done_o,
  output cs_store_pkg::cs_out_t res_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [DATA_W-1:0]     mem_wdata_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  logic [DATA_W-1:0]     mem_rdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_WR    = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_LOOK  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     cur_q, cur_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     stop_q, stop_d;
  logic              dir_q, dir_d;
  logic [DATA_W-1:0] word_q, word_d;
  logic [1:0]        status_q, status_d;

  logic [CW-1:0]     nxt;
  logic [CW-1:0]     ins_pos;
  logic              valid;
  logic              full;

  // Shared index unit: steps down while opening a gap, up while closing one.
  assign nxt   = dir_q ? (idx_q - CW'(1)) : (idx_q + CW'(1));
  assign valid = (cur_q < cnt_q);
  assign full  = (cnt_q == CW'(CAPACITY));

  // Slot that a new word lands in for insert or attach.
  always_comb begin
    if (item_i.op == cs_store_pkg::OP_ATTACH) begin
      ins_pos = valid ? (cur_q + CW'(1)) : cnt_q;
    end else begin
      ins_pos = valid ? cur_q : '0;
    end
  end

  // Sequencer: decode, move words one at a time, place, then look up the cursor.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    stop_d      = stop_q;
    dir_d       = dir_q;
    word_d      = word_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = nxt[AW-1:0];
    done_o      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          word_d   = DATA_W'(item_i.entry_value);
          status_d = cs_store_pkg::ST_OK;
          state_d  = S_FETCH;
          unique case (item_i.op)
            cs_store_pkg::OP_INSERT, cs_store_pkg::OP_ATTACH: begin
              if (full) begin
                status_d = cs_store_pkg::ST_FULL;
              end else begin
                cur_d   = ins_pos;
                stop_d  = ins_pos;
                idx_d   = cnt_q;
                dir_d   = 1'b1;
                state_d = (cnt_q > ins_pos) ? S_RD : S_PUT;
              end
            end
            cs_store_pkg::OP_REMOVE: begin
              if (!valid) begin
                status_d = cs_store_pkg::ST_NOCUR;
              end else if (cur_q != cnt_q - CW'(1)) begin
                idx_d   = cur_q;
                stop_d  = cnt_q - CW'(1);
                dir_d   = 1'b0;
                state_d = S_RD;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            cs_store_pkg::OP_ADVANCE: begin
              if (!valid) begin
                status_d = cs_store_pkg::ST_NOCUR;
              end else begin
                cur_d = cur_q + CW'(1);
              end
            end
            cs_store_pkg::OP_READ: begin
              if (!valid) begin
                status_d = cs_store_pkg::ST_NOCUR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        mem_we_o = 1'b1;
        idx_d    = nxt;
        if (nxt != stop_q) begin
          state_d = S_RD;
        end else if (dir_q) begin
          state_d = S_PUT;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_FETCH;
        end
      end
      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cur_q[AW-1:0];
        mem_wdata_o = word_q;
        cnt_d       = cnt_q + CW'(1);
        state_d     = S_FETCH;
      end
      S_FETCH: begin
        mem_raddr_o = cur_q[AW-1:0];
        state_d     = S_LOOK;
      end
      S_LOOK: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    stop_q   <= stop_d;
    dir_q    <= dir_d;
    word_q   <= word_d;
    status_q <= status_d;
  end

  assign busy_o = (state_q != S_IDLE);

  // Result fields, valid while the sequencer is in its lookup state.
  always_comb begin
    res_o.current_value = valid ? 32'(mem_rdata_i) : '0;
    res_o.has_current   = valid;
    res_o.item_count    = 7'(cnt_q);
    res_o.cursor_pos    = 7'(cur_q);
    res_o.status        = status_q;
  end

  // The cursor never passes the end of the stored words.
  a_cur_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= cnt_q) else $error("cursor beyond item count");

  // The count never exceeds the capacity.
  a_cnt_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY)) else $error("item count beyond capacity");

  // An accepted transaction makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_o) |=> busy_o) else $error("accepted transaction not started");

  // A result is followed by a return to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("sequencer not idle after result");

  // Memory writes happen only while moving or placing words.
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_WR || state_q == S_PUT))
    else $error("memory write outside a move or place step");

endmodule

// ===== design/cursor_sequence_store_core.sv =====
`timescale 1ns / 1ps

// Ordered store of up to CAPACITY words with a cursor marking the current word.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low; item_i carries the op code and the word to place. Result channel:
// done_o is high for exactly one cycle and result_o holds the count, cursor,
// current word and status at that cycle; the receiver cannot stall it.
// Each command is executed by a small sequencer around one store with one write
// port and one read port. Opening or closing a gap moves one word at a time, a
// read and then a write per word, so busy stays high longer the more words a
// command moves. done_o rises in the same cycle that busy falls, and the next
// command may be taken while that result is shown. The longest command is an
// insert at the front of CAPACITY - 1 words, which moves every stored word.
// Reset clears the count and cursor and returns to idle; the stored words are
// not cleared, as words beyond the count never reach the result.
module cursor_sequence_store_core #(
  parameter int CAPACITY = 64,
  parameter int DATA_W   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cs_store_pkg::cs_in_t  item_i,
  output logic                  done_o,
  output cs_store_pkg::cs_out_t result_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_W-1:0]     mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_W-1:0]     mem_rdata;
  logic                  seq_done;
  cs_store_pkg::cs_out_t seq_res;
  logic                  done_q;
  cs_store_pkg::cs_out_t result_q;

  cs_store_seq #(
    .CAPACITY (CAPACITY),
    .DATA_W   (DATA_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_i),
    .busy_o      (busy),
    .done_o      (seq_done),
    .res_o       (seq_res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  cs_store_mem #(
    .DEPTH  (CAPACITY),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result strobe register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= seq_done;
    end
  end

  // Result payload register, loaded when the sequencer finishes a transaction.
  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      result_q <= seq_res;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
